// File: rtl/shabs_pkg.sv
package shabs_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned BlockW = 512;
  localparam int unsigned CntW   = 6;
  localparam int unsigned LenW   = 64;
  localparam int unsigned DigW   = 256;

  localparam logic [7:0]      PAD_MARK_BYTE = 8'h80;
  localparam logic [7:0]      PAD_ZERO_BYTE = 8'h00;
  localparam logic [CntW-1:0] CNT_LAST      = 6'd63;
  localparam logic [CntW-1:0] CNT_LEN_START = 6'd56;
  localparam logic [CntW-1:0] ROUND_LAST    = 6'd63;
  localparam logic [LenW-1:0] BLOCK_BITS    = 64'd512;

  localparam logic [WordW-1:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  // where to go once a compression finishes
  typedef enum logic [1:0] {
    RET_DATA,
    RET_PAD,
    RET_FINAL
  } ret_e;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic      shift_en;
    byte_sel_e sel;
    logic      latch_len;
    logic      load_vars;
    logic      round_en;
    logic      add_chain;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic cnt_len_start;
    logic round_last;
    logic out_busy;
  } sts_t;

endpackage

// File: rtl/shabs_ctrl.sv
module shabs_ctrl
  import shabs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_finish_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= RET_DATA;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_finish_i) begin
            state_d = ST_PAD_MARK;
          end else if (sts_i.cnt_last) begin
            state_d = ST_ROUND;
            ret_d   = RET_DATA;
          end
        end
      end
      ST_PAD_MARK: begin
        if (sts_i.cnt_last) begin
          state_d = ST_ROUND;
          ret_d   = RET_PAD;
        end else begin
          state_d = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (sts_i.cnt_len_start) begin
          state_d = ST_LEN;
        end else if (sts_i.cnt_last) begin
          state_d = ST_ROUND;
          ret_d   = RET_PAD;
        end
      end
      ST_LEN: begin
        if (sts_i.cnt_last) begin
          state_d = ST_ROUND;
          ret_d   = RET_FINAL;
        end
      end
      ST_ROUND: begin
        if (sts_i.round_last) state_d = ST_ADD;
      end
      ST_ADD: begin
        unique case (ret_q)
          RET_DATA:  state_d = ST_IDLE;
          RET_PAD:   state_d = ST_PAD_ZERO;
          RET_FINAL: state_d = ST_EMIT;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = SEL_DATA;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_finish_i) begin
            cmd_o.latch_len = 1'b1;
          end else begin
            cmd_o.shift_en  = 1'b1;
            cmd_o.load_vars = sts_i.cnt_last;
          end
        end
      end
      ST_PAD_MARK: begin
        cmd_o.shift_en  = 1'b1;
        cmd_o.sel       = SEL_MARK;
        cmd_o.load_vars = sts_i.cnt_last;
      end
      ST_PAD_ZERO: begin
        if (!sts_i.cnt_len_start) begin
          cmd_o.shift_en  = 1'b1;
          cmd_o.sel       = SEL_ZERO;
          cmd_o.load_vars = sts_i.cnt_last;
        end
      end
      ST_LEN: begin
        cmd_o.shift_en  = 1'b1;
        cmd_o.sel       = SEL_LEN;
        cmd_o.load_vars = sts_i.cnt_last;
      end
      ST_ROUND: cmd_o.round_en  = 1'b1;
      ST_ADD:   cmd_o.add_chain = 1'b1;
      ST_EMIT:  cmd_o.emit      = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

// File: rtl/shabs_datapath.sv
module shabs_datapath
  import shabs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  logic [BlockW-1:0] buf_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   rnd_q;
  logic [LenW-1:0]   bits_q;
  logic [LenW-1:0]   len_q;
  logic [WordW-1:0]  h_q [8];
  logic [WordW-1:0]  v_q [8];
  logic [DigW-1:0]   dig_q;
  logic              out_valid_q;
  logic [2:0]        out_idx_q;

  logic [7:0]       byte_in;
  logic [WordW-1:0] w_cur, w1, w9, w14, s0, s1, w_new;
  logic [WordW-1:0] big0, big1, ch, maj, t1, t2;

  always_comb begin
    unique case (cmd_i.sel)
      SEL_DATA: byte_in = data_byte_i;
      SEL_MARK: byte_in = PAD_MARK_BYTE;
      SEL_ZERO: byte_in = PAD_ZERO_BYTE;
      SEL_LEN:  byte_in = len_q[LenW-1 -: 8];
      default:  byte_in = PAD_ZERO_BYTE;
    endcase
  end

  // message schedule: the block buffer doubles as the 16-word window
  assign w_cur = buf_q[BlockW-1         -: WordW];
  assign w1    = buf_q[BlockW-1-WordW   -: WordW];
  assign w9    = buf_q[BlockW-1-9*WordW -: WordW];
  assign w14   = buf_q[BlockW-1-14*WordW -: WordW];
  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w_cur;

  assign big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1   = v_q[7] + big1 + ch + ROUND_K[rnd_q] + w_cur;
  assign big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = big0 + maj;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_en) begin
      buf_q <= {buf_q[BlockW-9:0], byte_in};
    end else if (cmd_i.round_en) begin
      buf_q <= {buf_q[BlockW-WordW-1:0], w_new};
    end
    if (cmd_i.latch_len) begin
      len_q <= bits_q + {{(LenW-CntW-3){1'b0}}, cnt_q, 3'b000};
    end else if (cmd_i.shift_en && cmd_i.sel == SEL_LEN) begin
      len_q <= {len_q[LenW-9:0], 8'h00};
    end
    if (cmd_i.load_vars) begin
      v_q <= h_q;
    end else if (cmd_i.round_en) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (cmd_i.emit) begin
      dig_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
    end else if (out_valid_q && out_ready_i) begin
      dig_q <= {dig_q[DigW-WordW-1:0], {WordW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rnd_q       <= '0;
      bits_q      <= '0;
      h_q         <= INIT_H;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      if (cmd_i.shift_en) cnt_q <= cnt_q + 6'd1;
      if (cmd_i.round_en) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.emit) begin
        h_q    <= INIT_H;
        bits_q <= '0;
      end else if (cmd_i.add_chain) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        bits_q <= bits_q + BLOCK_BITS;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        out_idx_q   <= '0;
      end else if (out_valid_q && out_ready_i) begin
        out_idx_q <= out_idx_q + 3'd1;
        if (out_idx_q == 3'd7) out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.cnt_last      = (cnt_q == CNT_LAST);
  assign sts_o.cnt_len_start = (cnt_q == CNT_LEN_START);
  assign sts_o.round_last    = (rnd_q == ROUND_LAST);
  assign sts_o.out_busy      = out_valid_q;

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = dig_q[DigW-1 -: WordW];
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == 3'd7);

endmodule

// File: rtl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream.
// Slave channel: one item per message byte (s_tuser = 0, byte in s_tdata),
// or a finish item (s_tuser = 1, s_tdata ignored) that pads the message,
// runs the closing compressions and queues the 256-bit digest.
// Master channel: eight items per digest, word 0 first; m_tlast marks word 7.
// Input flow: data bytes are taken while idle; every 64th byte completes a
// block, and s_tready is low while its 64 rounds and the chaining add run.
// A finish shifts in the 0x80 mark, zero bytes and the 64-bit bit length,
// compressing each full block, then loads the digest into the output
// register; padding needs one extra block when p, the pending byte count,
// is 56 or more. With its own output register the digest drains while new
// message bytes are taken. A receiver stall holds that register; a further
// finish is taken, but its digest waits until the previous one has left.
// Reset: chaining words return to the initial hash values, byte and bit counts
// clear, the output register empties. Each digest restores all but the last.
module sha256_byte_stream_hasher
  import shabs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        m_tlast
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  shabs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_finish_i (s_tuser),
    .in_ready_o  (s_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  shabs_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (s_tdata),
    .out_valid_o   (m_tvalid),
    .out_ready_i   (m_tready),
    .digest_word_o (digest_word),
    .word_index_o  (word_index),
    .last_word_o   (m_tlast)
  );

  assign m_tdata = {5'b00000, word_index, digest_word};

endmodule

// File: rtl/shabs_checker.sv
module shabs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // stalled digest word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("digest word changed under stall");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
    else $error("tlast does not match word index");

  // after a non-last word leaves, the next word is valid with the next index
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tdata[34:32] == 3'($past(m_tdata[34:32]) + 3'd1)))
    else $error("digest word index skipped");

  // a finish starts padding, so no item is taken right after it
  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input taken right after finish");

endmodule

bind sha256_byte_stream_hasher shabs_checker u_shabs_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import shabs_pkg::*;

  typedef enum logic {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } hash_cmd_e;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  // one row of the directed table; a row may repeat its byte several times
  typedef struct packed {
    hash_cmd_e    cmd;
    logic [7:0]   data;
    int unsigned  reps;
    logic         has_digest;
    logic [255:0] digest;
  } dir_row_t;

  localparam int unsigned NumDirRows = 12;
  localparam logic [255:0] DigestEmpty =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] DigestAbc =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tuser = 1'b0;    // [0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [31:0] digest_word, [34:32] word_index, [39:35] zero
  logic        m_tlast;

  sha256_byte_stream_hasher dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // predictor state
  logic [31:0] chain_h [8];
  logic [7:0]  blk_buf [64];
  int unsigned blk_fill;
  logic [63:0] bits_hashed;

  digest_word_t digest_q [$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned msgs_done = 0;
  int unsigned long_tails = 0;

  dir_row_t dir_rows [NumDirRows] = '{
    '{CMD_FINISH, 8'h00,  1, 1'b1, DigestEmpty},  // empty message straight out of reset
    '{CMD_ABSORB, 8'h61,  1, 1'b0, '0},
    '{CMD_ABSORB, 8'h62,  1, 1'b0, '0},
    '{CMD_ABSORB, 8'h63,  1, 1'b0, '0},
    '{CMD_FINISH, 8'hff,  1, 1'b1, DigestAbc},
    '{CMD_ABSORB, 8'h00,  1, 1'b0, '0},
    '{CMD_ABSORB, 8'hff,  1, 1'b0, '0},
    '{CMD_FINISH, 8'hff,  1, 1'b0, '0},
    '{CMD_ABSORB, 8'hff, 56, 1'b0, '0},           // long tail: needs the extra length block
    '{CMD_FINISH, 8'h00,  1, 1'b0, '0},
    '{CMD_ABSORB, 8'h00, 64, 1'b0, '0},           // exactly one full block, then an empty tail
    '{CMD_FINISH, 8'h5a,  1, 1'b0, '0}
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("sha256_byte_stream_hasher regression: fail");
    $finish;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int r = 0; r < 16; r++) begin
      w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
    end
    for (int r = 16; r < 64; r++) begin
      w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
           + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
    end
    for (int r = 0; r < 8; r++) v[r] = chain_h[r];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int r = 0; r < 8; r++) chain_h[r] = chain_h[r] + v[r];
  endfunction

  function automatic void hasher_clear();
    for (int j = 0; j < 8; j++) chain_h[j] = INIT_H[j];
    for (int j = 0; j < 64; j++) blk_buf[j] = 8'h00;
    blk_fill = 0;
    bits_hashed = '0;
  endfunction

  // advance the predictor by one accepted item, queue the digest on finish
  function automatic void hash_item(input hash_cmd_e cmd, input logic [7:0] data);
    logic [63:0] total;
    digest_word_t dw;
    if (cmd == CMD_ABSORB) begin
      blk_buf[blk_fill] = data;
      blk_fill++;
      if (blk_fill == 64) begin
        sha_compress();
        bits_hashed = bits_hashed + BLOCK_BITS;
        blk_fill = 0;
      end
      return;
    end
    blk_buf[blk_fill] = PAD_MARK_BYTE;
    for (int j = blk_fill + 1; j < 64; j++) blk_buf[j] = PAD_ZERO_BYTE;
    if (blk_fill >= CNT_LEN_START) begin
      long_tails++;
      sha_compress();
      for (int j = 0; j < 56; j++) blk_buf[j] = PAD_ZERO_BYTE;
    end
    total = bits_hashed + 64'(blk_fill) * 8;
    for (int j = 0; j < 8; j++) blk_buf[63-j] = total[8*j +: 8];
    sha_compress();
    for (int j = 0; j < 8; j++) begin
      dw.word = chain_h[j];
      dw.idx = 3'(j);
      dw.last = (j == 7);
      digest_q.push_back(dw);
    end
    hasher_clear();
  endfunction

  task automatic send_item(input hash_cmd_e cmd, input logic [7:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= data;
    do @(posedge clk_i); while (!s_tready);
    hash_item(cmd, data);
    if (cmd == CMD_ABSORB) bytes_sent++;
    else msgs_done++;
  endtask

  // hold the sender off until every queued digest word has left
  task automatic drain_digests();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_message(input int unsigned len);
    for (int k = 0; k < len; k++) send_item(CMD_ABSORB, 8'($urandom_range(255)));
    send_item(CMD_FINISH, 8'($urandom_range(255)));
  endtask

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        $error("digest word %h with no expectation pending", m_tdata[31:0]);
        mismatches++;
      end else begin
        digest_word_t exp_w;
        exp_w = digest_q.pop_front();
        words_checked++;
        if (m_tdata[31:0] !== exp_w.word) begin
          $error("digest_word: expected %h, got %h", exp_w.word, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[34:32] !== exp_w.idx) begin
          $error("word_index: expected %0d, got %0d", exp_w.idx, m_tdata[34:32]);
          mismatches++;
        end
        if (m_tlast !== exp_w.last) begin
          $error("last_word: expected %0d, got %0d", exp_w.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned len;
    int unsigned guard;
    int unsigned n_msg;
    int unsigned base;
    hasher_clear();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirRows; r++) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        if (dir_rows[r].cmd == CMD_FINISH && dir_rows[r].has_digest) begin
          send_item(dir_rows[r].cmd, dir_rows[r].data);
          // replace predicted words with the published digest
          base = digest_q.size() - 8;
          for (int j = 0; j < 8; j++) begin
            digest_q[base + j].word = dir_rows[r].digest[255 - 32*j -: 32];
          end
        end else begin
          send_item(dir_rows[r].cmd, dir_rows[r].data);
        end
      end
    end
    drain_digests();

    n_msg = 0;
    // every idle and stall mix gets at least one message
    while (bytes_sent + msgs_done < 320 || n_msg < 4) begin
      case (n_msg % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
        default: begin src_idle_pct = 15; snk_stall_pct = 15; end
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4: len = $urandom_range(15);
        5, 6, 7: len = $urandom_range(70, 16);
        8: begin
          case ($urandom_range(7))
            0: len = 55;
            1: len = 56;
            2: len = 63;
            3: len = 64;
            4: len = 119;
            5: len = 120;
            6: len = 127;
            default: len = 128;
          endcase
        end
        default: len = $urandom_range(140, 71);
      endcase
      if ($urandom_range(7) == 0) drain_digests();
      send_message(len);
      n_msg++;
    end

    s_tvalid <= 1'b0;
    guard = 0;
    while (digest_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (400) @(posedge clk_i);
    if (digest_q.size() != 0) begin
      $error("%0d digest words never arrived", digest_q.size());
      mismatches++;
    end

    $display("covered %0d messages (%0d with a long tail), %0d bytes, %0d digest words",
             msgs_done, long_tails, bytes_sent, words_checked);
    $display("idle and stall mixes on both channels, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("sha256_byte_stream_hasher regression: pass");
    end else begin
      $display("sha256_byte_stream_hasher regression: fail");
    end
    $finish;
  end

endmodule
